// ===== hdl/mmor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmor_pkg
// Shared types and constants of the masked multi-operand reducer.
// ----------------------------------------------------------------------------
package mmor_pkg;

   localparam int NUM_PORTS   = 7;
   localparam int IDX_W       = $clog2(NUM_PORTS);
   localparam int CNT_W       = $clog2(NUM_PORTS + 1);
   localparam int PORT_W      = 3;
   localparam int Q_W         = 48;
   localparam int CONST_W     = 16;
   localparam int MASK_GRP    = 7;
   localparam int MASKS_W     = 49;
   localparam int INV_W       = 7;
   localparam int CLO_W       = 64;
   localparam int CHI_W       = 48;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_OR  = 3'd0;
   localparam logic [OP_W-1:0] OP_XOR = 3'd1;
   localparam logic [OP_W-1:0] OP_AND = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD = 3'd3;
   localparam logic [OP_W-1:0] OP_SUB = 3'd4;
   localparam logic [OP_W-1:0] OP_MUL = 3'd5;
   localparam logic [OP_W-1:0] OP_DIV = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DZ  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_MASKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_BITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTS_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTS_HIGH = 3'd4;

   localparam logic signed [Q_W-1:0] QMAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [Q_W-1:0] QMIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic                    is_read;
      logic [IDX_W-1:0]        idx;
      logic signed [Q_W-1:0]   operand;
   } job_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [MASKS_W-1:0] input_masks;
      logic [INV_W-1:0]   invert_bits;
      logic [CLO_W-1:0]   consts_low;
      logic [CHI_W-1:0]   consts_high;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic is_div;
      logic frac8;
   } md_req_type;

   typedef struct packed {
      logic done;
      logic ovf;
      logic dz;
   } md_rsp_type;

endpackage

// ===== hdl/masked_multi_operand_reducer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_multi_operand_reducer_unit
// Seven Q32.16 inputs reduced per output under a configurable mask.
//
// Request channel (req_*): func 0 writes operand to input <port>, func 1 reads
// output <port>. A port of 0 or above 7 is dropped without effect.
// Response channel (rsp_*): one response per valid read: Q32.16 value, the
// output number and status (ok, division by zero, overflow saturated).
// Configuration (csr_*): register index and data, written on csr_write.
// Requests enter a front register and a two-entry queue; the back end works
// on one request at a time. Mul and div add one pass of the shared iterative
// unit per selected input after the first plus one for the constant.
// Reset clears the inputs to zero and loads the register defaults.
// A stalled response holds; the back end waits at its end until it is taken
// while new requests keep filling the queue.
// ----------------------------------------------------------------------------
module masked_multi_operand_reducer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [mmor_pkg::PORT_W-1:0]           req_port,
   input  logic signed [mmor_pkg::Q_W-1:0]       req_operand,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mmor_pkg::Q_W-1:0]       rsp_result_value,
   output logic [mmor_pkg::PORT_W-1:0]           rsp_result_port,
   output logic [mmor_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                  csr_write,
   input  logic [mmor_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mmor_pkg::CSR_DATA_W-1:0]       csr_data
);
   import mmor_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, queue_full, pop, head_valid;
   job_type push_job, head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_OPERATION:   cfg_in.operation   = csr_data[OP_W-1:0];
            CSR_INPUT_MASKS: cfg_in.input_masks = csr_data[MASKS_W-1:0];
            CSR_INVERT_BITS: cfg_in.invert_bits = csr_data[INV_W-1:0];
            CSR_CONSTS_LOW:  cfg_in.consts_low  = csr_data[CLO_W-1:0];
            CSR_CONSTS_HIGH: cfg_in.consts_high = csr_data[CHI_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.operation   <= OP_OR;
         cfg_ff.input_masks <= MASKS_W'(15);
         cfg_ff.invert_bits <= '0;
         cfg_ff.consts_low  <= '0;
         cfg_ff.consts_high <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmor_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_port    (req_port),
      .req_operand (req_operand),
      .push        (push),
      .push_job    (push_job),
      .queue_full  (queue_full)
   );

   mmor_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mmor_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_port  (rsp_result_port),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== hdl/mmor_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmor_front
// Accepts requests, drops those with an out-of-range port, and hands decoded
// jobs to the queue.
// ----------------------------------------------------------------------------
module mmor_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_func,
   input  logic [mmor_pkg::PORT_W-1:0]             req_port,
   input  logic signed [mmor_pkg::Q_W-1:0]         req_operand,
   output logic                                    push,
   output mmor_pkg::job_type                       push_job,
   input  logic                                    queue_full
);
   import mmor_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    take, port_ok;

   assign req_stall = valid_ff && queue_full;
   assign take      = req_valid && !req_stall;
   assign port_ok   = (req_port != '0) && (req_port <= PORT_W'(NUM_PORTS));
   assign push      = valid_ff;
   assign push_job  = job_ff;

   always_comb begin
      valid_in = valid_ff && queue_full;
      job_in   = job_ff;
      if (take) begin
         valid_in       = port_ok;
         job_in.is_read = req_func;
         job_in.idx     = IDX_W'(req_port - 1'b1);
         job_in.operand = req_operand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

// ===== hdl/mmor_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmor_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module mmor_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mmor_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mmor_pkg::job_type head_job
);
   import mmor_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/mmor_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmor_muldiv
// Shared iterative fixed-point multiplier / divider: shift-add multiply in
// 48 steps, restoring divide in 64 steps, then round and saturate.
// ----------------------------------------------------------------------------
module mmor_muldiv (
   input  logic                             clock,
   input  logic                             reset,
   input  mmor_pkg::md_req_type             md_req,
   input  logic signed [mmor_pkg::Q_W-1:0]  md_a,
   input  logic signed [mmor_pkg::Q_W-1:0]  md_b,
   output mmor_pkg::md_rsp_type             md_rsp,
   output logic signed [mmor_pkg::Q_W-1:0]  md_res
);
   import mmor_pkg::*;

   typedef enum logic [3:0] {
      MD_IDLE = 4'b0001,
      MD_MUL  = 4'b0010,
      MD_DIV  = 4'b0100,
      MD_FIN  = 4'b1000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         neg_ff, neg_in, frac8_ff, frac8_in, div_ff, div_in;
   logic         zero_ff, zero_in, apos_ff, apos_in, aneg_ff, aneg_in;
   logic [95:0]  mcand_ff, mcand_in, prod_ff, prod_in;
   logic [47:0]  mplier_ff, mplier_in, rem_ff, rem_in, den_ff, den_in;
   logic [63:0]  num_ff, num_in, quo_ff, quo_in;
   logic         done_ff, done_in, ovf_ff, ovf_in, dz_ff, dz_in;
   logic signed [Q_W-1:0] res_ff, res_in;

   logic [47:0]  mag_a, mag_b;
   logic [48:0]  trial, diff;
   logic         ge, div_up, over;
   logic [96:0]  mul_rnd;
   logic [88:0]  mul_q, div_q, mag_q, lim;

   assign md_rsp.done = done_ff;
   assign md_rsp.ovf  = ovf_ff;
   assign md_rsp.dz   = dz_ff;
   assign md_res      = res_ff;

   always_comb begin
      mag_a   = md_a[Q_W-1] ? 48'(~md_a + 1'b1) : 48'(md_a);
      mag_b   = md_b[Q_W-1] ? 48'(~md_b + 1'b1) : 48'(md_b);
      trial   = {rem_ff, num_ff[63]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      mul_rnd = {1'b0, prod_ff} + (frac8_ff ? 97'h80 : 97'h8000);
      mul_q   = frac8_ff ? mul_rnd[96:8] : {8'b0, mul_rnd[96:16]};
      div_up  = {rem_ff, 1'b0} >= {1'b0, den_ff};
      div_q   = {24'b0, {1'b0, quo_ff} + 65'(div_up)};
      mag_q   = div_ff ? div_q : mul_q;
      lim     = neg_ff ? 89'h8000_0000_0000 : 89'h7FFF_FFFF_FFFF;
      over    = mag_q > lim;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      frac8_in  = frac8_ff;
      div_in    = div_ff;
      zero_in   = zero_ff;
      apos_in   = apos_ff;
      aneg_in   = aneg_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;
      ovf_in    = ovf_ff;
      dz_in     = dz_ff;
      res_in    = res_ff;

      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               neg_in    = md_a[Q_W-1] ^ md_b[Q_W-1];
               frac8_in  = md_req.frac8;
               div_in    = md_req.is_div;
               zero_in   = md_b == '0;
               apos_in   = !md_a[Q_W-1] && (md_a != '0);
               aneg_in   = md_a[Q_W-1];
               cnt_in    = '0;
               mcand_in  = {48'b0, mag_a};
               mplier_in = mag_b;
               prod_in   = '0;
               den_in    = mag_b;
               rem_in    = '0;
               quo_in    = '0;
               num_in    = md_req.frac8 ? {8'b0, mag_a, 8'b0} : {mag_a, 16'b0};
               if (!md_req.is_div) begin
                  state_in = MD_MUL;
               end else if (md_b == '0) begin
                  state_in = MD_FIN;
               end else begin
                  state_in = MD_DIV;
               end
            end
         end
         MD_MUL: begin
            prod_in   = prod_ff + (mplier_ff[0] ? mcand_ff : 96'd0);
            mcand_in  = {mcand_ff[94:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[47:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == 6'd47) begin
               state_in = MD_FIN;
            end
         end
         MD_DIV: begin
            rem_in = ge ? diff[47:0] : trial[47:0];
            quo_in = {quo_ff[62:0], ge};
            num_in = {num_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               state_in = MD_FIN;
            end
         end
         MD_FIN: begin
            done_in  = 1'b1;
            state_in = MD_IDLE;
            if (div_ff && zero_ff) begin
               dz_in  = 1'b1;
               ovf_in = 1'b0;
               res_in = apos_ff ? QMAX : (aneg_ff ? QMIN : '0);
            end else begin
               dz_in  = 1'b0;
               ovf_in = over;
               if (over) begin
                  res_in = neg_ff ? QMIN : QMAX;
               end else begin
                  res_in = neg_ff ? -$signed(mag_q[47:0]) : $signed(mag_q[47:0]);
               end
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      frac8_ff  <= frac8_in;
      div_ff    <= div_in;
      zero_ff   <= zero_in;
      apos_ff   <= apos_in;
      aneg_ff   <= aneg_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      ovf_ff    <= ovf_in;
      dz_ff     <= dz_in;
      res_ff    <= res_in;
   end

endmodule

// ===== hdl/mmor_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmor_back
// Executes queued jobs: stores input values, and walks the selected inputs
// of a read one per step, using the shared multiply/divide unit for mul and div.
// ----------------------------------------------------------------------------
module mmor_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mmor_pkg::cfg_type                    cfg,
   input  logic                                 head_valid,
   input  mmor_pkg::job_type                    head_job,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mmor_pkg::Q_W-1:0]      rsp_result_value,
   output logic [mmor_pkg::PORT_W-1:0]          rsp_result_port,
   output logic [mmor_pkg::STATUS_W-1:0]        rsp_status
);
   import mmor_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_SCAN  = 5'b00010,
      B_WAIT  = 5'b00100,
      B_CONST = 5'b01000,
      B_DONE  = 5'b10000
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic signed [Q_W-1:0] store_ff [NUM_PORTS];
   logic                  store_we;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [NUM_PORTS-1:0]  mask_ff, mask_in;
   logic signed [CONST_W-1:0] cval_ff, cval_in;
   logic signed [Q_W-1:0] acc_ff, acc_in;
   logic [31:0]           bits_ff, bits_in;
   logic                  first_ff, first_in, ovf_ff, ovf_in, dz_ff, dz_in;
   logic                  const_ff, const_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [Q_W-1:0] rsp_value_ff, rsp_value_in;
   logic [PORT_W-1:0]     rsp_port_ff, rsp_port_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   md_req_type            md_req;
   md_rsp_type            md_rsp;
   logic signed [Q_W-1:0] md_b, md_res;

   logic signed [Q_W-1:0] store_v, cext, cval48;
   logic [MASK_GRP-1:0]   grp;
   logic [CLO_W+CHI_W-1:0] consts_all;
   logic [47:0]           rmag;
   logic [32:0]           rm;
   logic [31:0]           rbits, bits_fin;
   logic                  rovf;
   logic [48:0]           add_s, sub_s, cadd_s, csub_s;

   function automatic logic signed [Q_W-1:0] sat49(input logic [48:0] s);
      logic signed [Q_W-1:0] r;
      if (s[48] != s[47]) begin
         r = s[48] ? QMIN : QMAX;
      end else begin
         r = $signed(s[47:0]);
      end
      return r;
   endfunction

   mmor_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_a   (acc_ff),
      .md_b   (md_b),
      .md_rsp (md_rsp),
      .md_res (md_res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_port  = rsp_port_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      store_v    = store_ff[j_ff[IDX_W-1:0]];
      consts_all = {cfg.consts_high, cfg.consts_low};
      grp        = cfg.input_masks[MASK_GRP*head_job.idx +: MASK_GRP];
      cval48     = Q_W'(cval_ff);
      cext       = {cval48[Q_W-9:0], 8'b0};

      // round to nearest integer, ties away from zero, saturate to 32 bits
      rmag = store_v[Q_W-1] ? 48'(~store_v + 1'b1) : 48'(store_v);
      rm   = 33'(({1'b0, rmag} + 49'h8000) >> 16);
      rovf = 1'b0;
      if (!store_v[Q_W-1]) begin
         if (rm > 33'h7FFF_FFFF) begin
            rovf  = 1'b1;
            rbits = 32'h7FFF_FFFF;
         end else begin
            rbits = rm[31:0];
         end
      end else begin
         if (rm > 33'h8000_0000) begin
            rovf  = 1'b1;
            rbits = 32'h8000_0000;
         end else begin
            rbits = 32'(~rm[31:0] + 1'b1);
         end
      end

      add_s    = {acc_ff[Q_W-1], acc_ff} + {store_v[Q_W-1], store_v};
      sub_s    = {acc_ff[Q_W-1], acc_ff} - {store_v[Q_W-1], store_v};
      cadd_s   = {acc_ff[Q_W-1], acc_ff} + {cext[Q_W-1], cext};
      csub_s   = {acc_ff[Q_W-1], acc_ff} - {cext[Q_W-1], cext};
      bits_fin = cfg.invert_bits[idx_ff] ? ~bits_ff : bits_ff;

      state_in      = state_ff;
      j_in          = j_ff;
      idx_in        = idx_ff;
      mask_in       = mask_ff;
      cval_in       = cval_ff;
      acc_in        = acc_ff;
      bits_in       = bits_ff;
      first_in      = first_ff;
      ovf_in        = ovf_ff;
      dz_in         = dz_ff;
      const_in      = const_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      store_we      = 1'b0;
      md_req.start  = 1'b0;
      md_req.is_div = cfg.operation == OP_DIV;
      md_req.frac8  = 1'b0;
      md_b          = store_v;

      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (!head_job.is_read) begin
                  store_we = 1'b1;
               end else begin
                  idx_in   = head_job.idx;
                  mask_in  = grp[NUM_PORTS-1:0];
                  cval_in  = consts_all[CONST_W*head_job.idx +: CONST_W];
                  acc_in   = '0;
                  bits_in  = (cfg.operation == OP_AND) ? 32'hFFFF_FFFF : 32'h0;
                  first_in = 1'b1;
                  ovf_in   = 1'b0;
                  dz_in    = 1'b0;
                  const_in = 1'b0;
                  j_in     = '0;
                  state_in = (cfg.operation > OP_DIV) ? B_DONE : B_SCAN;
               end
            end
         end
         B_SCAN: begin
            if (j_ff == CNT_W'(NUM_PORTS)) begin
               if (cfg.operation <= OP_AND) begin
                  acc_in   = {bits_fin, 16'b0};
                  state_in = B_DONE;
               end else begin
                  state_in = B_CONST;
               end
            end else begin
               j_in = j_ff + 1'b1;
               if (mask_ff[j_ff[IDX_W-1:0]]) begin
                  priority if (cfg.operation == OP_OR) begin
                     bits_in = bits_ff | rbits;
                     ovf_in  = ovf_ff | rovf;
                  end else if (cfg.operation == OP_XOR) begin
                     bits_in = bits_ff ^ rbits;
                     ovf_in  = ovf_ff | rovf;
                  end else if (cfg.operation == OP_AND) begin
                     bits_in = bits_ff & rbits;
                     ovf_in  = ovf_ff | rovf;
                  end else if (cfg.operation == OP_ADD) begin
                     acc_in = sat49(add_s);
                     ovf_in = ovf_ff | (add_s[48] != add_s[47]);
                  end else if (first_ff) begin
                     acc_in   = store_v;
                     first_in = 1'b0;
                  end else if (cfg.operation == OP_SUB) begin
                     acc_in = sat49(sub_s);
                     ovf_in = ovf_ff | (sub_s[48] != sub_s[47]);
                  end else begin
                     md_req.start = 1'b1;
                     state_in     = B_WAIT;
                  end
               end
            end
         end
         B_WAIT: begin
            if (md_rsp.done) begin
               acc_in   = md_res;
               ovf_in   = ovf_ff | md_rsp.ovf;
               dz_in    = dz_ff | md_rsp.dz;
               state_in = const_ff ? B_DONE : B_SCAN;
            end
         end
         B_CONST: begin
            if (cfg.operation == OP_ADD) begin
               acc_in   = sat49(cadd_s);
               ovf_in   = ovf_ff | (cadd_s[48] != cadd_s[47]);
               state_in = B_DONE;
            end else if (cfg.operation == OP_SUB) begin
               acc_in   = sat49(csub_s);
               ovf_in   = ovf_ff | (csub_s[48] != csub_s[47]);
               state_in = B_DONE;
            end else begin
               md_b         = cval48;
               md_req.frac8 = 1'b1;
               md_req.start = 1'b1;
               const_in     = 1'b1;
               state_in     = B_WAIT;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_port_in   = PORT_W'(idx_ff) + 1'b1;
               rsp_status_in = dz_ff ? ST_DZ : (ovf_ff ? ST_OVF : ST_OK);
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PORTS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            store_ff[head_job.idx] <= head_job.operand;
         end
      end
      j_ff          <= j_in;
      idx_ff        <= idx_in;
      mask_ff       <= mask_in;
      cval_ff       <= cval_in;
      acc_ff        <= acc_in;
      bits_ff       <= bits_in;
      first_ff      <= first_in;
      ovf_ff        <= ovf_in;
      dz_ff         <= dz_in;
      const_ff      <= const_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
